/* design/ordered_list_insert_defines.svh */
// ----------------------------------------------------------------------------
// ordered list insert assertion macros
// shared property wrappers for the ordered list store
// ----------------------------------------------------------------------------
`ifndef ORDERED_LIST_INSERT_DEFINES_SVH
`define ORDERED_LIST_INSERT_DEFINES_SVH

// same-cycle implication, idle during reset
`define OLI_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("oli assertion failed");

// next-cycle implication, idle during reset
`define OLI_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("oli assertion failed");

`endif

/* design/oli_pkg.sv */
// ----------------------------------------------------------------------------
// oli_pkg
// types and constants for the ordered list store
// ----------------------------------------------------------------------------
package oli_pkg;

  localparam int DEPTH = 16;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int VW    = 32;

  localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);

  typedef enum logic [1:0] {
    KIND_PREPEND = 2'd0,
    KIND_INSERT  = 2'd1,
    KIND_READ    = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  typedef enum logic [1:0] {
    ST_STORED = 2'd0,
    ST_FULL   = 2'd1,
    ST_ENTRY  = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_INS,
    S_RD
  } state_t;

  typedef struct packed {
    logic [1:0]           kind;
    logic signed [VW-1:0] value;
  } item_t;

  typedef struct packed {
    logic [1:0]           status;
    logic signed [VW-1:0] entry_value;
    logic                 last;
  } result_t;

  typedef struct packed {
    logic          we;
    logic [AW-1:0] waddr;
    logic [VW-1:0] wdata;
    logic [AW-1:0] raddr;
  } ram_req_t;

endpackage

/* design/oli_ram.sv */
// ----------------------------------------------------------------------------
// oli_ram
// list entry store, one write and one registered read port
// ----------------------------------------------------------------------------
module oli_ram (
  input  logic                         clk,
  input  oli_pkg::ram_req_t            req,
  output logic [oli_pkg::VW-1:0]       rdata
);

  logic [oli_pkg::VW-1:0] mem [oli_pkg::DEPTH];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[req.raddr];
  end

endmodule

/* design/oli_seq.sv */
// ----------------------------------------------------------------------------
// oli_seq
// sweeps the entry store for ordered insert, prepend and read out
// ----------------------------------------------------------------------------
`include "ordered_list_insert_defines.svh"

module oli_seq (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  oli_pkg::item_t            item,
  output logic                      busy,
  output logic                      strobe,
  output oli_pkg::result_t          result,
  output oli_pkg::ram_req_t         ram_req,
  input  logic [oli_pkg::VW-1:0]    rdata
);

  oli_pkg::state_t              state, state_next;
  logic [oli_pkg::CW-1:0]       idx, idx_next;
  logic [oli_pkg::CW-1:0]       fill, fill_next;
  logic signed [oli_pkg::VW-1:0] val, val_next;
  logic signed [oli_pkg::VW-1:0] carry, carry_next;
  logic                         front, front_next;
  logic                         placed, placed_next;
  logic                         strobe_next;
  oli_pkg::result_t             result_next;

  logic                         accept;
  logic [oli_pkg::CW-1:0]       idx_inc;
  logic                         at_end;
  logic signed [oli_pkg::VW-1:0] rd_s;

  assign accept  = start && (state == oli_pkg::S_IDLE);
  assign busy    = (state != oli_pkg::S_IDLE);
  assign idx_inc = idx + 1'b1;
  assign at_end  = (idx == fill);
  assign rd_s    = rdata;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= oli_pkg::S_IDLE;
      fill   <= '0;
      strobe <= 1'b0;
    end else begin
      state  <= state_next;
      fill   <= fill_next;
      strobe <= strobe_next;
    end
  end

  always_ff @(posedge clk) begin
    idx    <= idx_next;
    val    <= val_next;
    carry  <= carry_next;
    front  <= front_next;
    placed <= placed_next;
    result <= result_next;
  end

  always_comb begin
    state_next    = state;
    idx_next      = idx;
    fill_next     = fill;
    val_next      = val;
    carry_next    = carry;
    front_next    = front;
    placed_next   = placed;
    strobe_next   = 1'b0;
    result_next   = '0;
    ram_req.we    = 1'b0;
    ram_req.waddr = idx[oli_pkg::AW-1:0];
    ram_req.wdata = val;
    ram_req.raddr = idx_inc[oli_pkg::AW-1:0];

    unique case (state)
      oli_pkg::S_IDLE: begin
        ram_req.raddr = '0;
        if (accept) begin
          idx_next    = '0;
          val_next    = item.value;
          front_next  = (item.kind == oli_pkg::KIND_PREPEND);
          placed_next = 1'b0;
          case (item.kind) inside
            oli_pkg::KIND_PREPEND, oli_pkg::KIND_INSERT: begin
              if (fill == oli_pkg::DEPTH_C) begin
                strobe_next        = 1'b1;
                result_next.status = oli_pkg::ST_FULL;
                result_next.last   = 1'b1;
              end else begin
                state_next = oli_pkg::S_INS;
              end
            end
            oli_pkg::KIND_READ: begin
              if (fill == '0) begin
                strobe_next        = 1'b1;
                result_next.status = oli_pkg::ST_EMPTY;
                result_next.last   = 1'b1;
              end else begin
                state_next = oli_pkg::S_RD;
              end
            end
            default: begin
            end
          endcase
        end
      end
      oli_pkg::S_INS: begin
        if (placed) begin
          ram_req.we    = 1'b1;
          ram_req.wdata = carry;
          carry_next    = rd_s;
        end else if (at_end || front || (rd_s >= val)) begin
          ram_req.we    = 1'b1;
          ram_req.wdata = val;
          carry_next    = rd_s;
          placed_next   = 1'b1;
        end
        if (at_end) begin
          fill_next          = fill + 1'b1;
          strobe_next        = 1'b1;
          result_next.status = oli_pkg::ST_STORED;
          result_next.last   = 1'b1;
          state_next         = oli_pkg::S_IDLE;
        end else begin
          idx_next = idx_inc;
        end
      end
      oli_pkg::S_RD: begin
        strobe_next             = 1'b1;
        result_next.status      = oli_pkg::ST_ENTRY;
        result_next.entry_value = rd_s;
        if (idx_inc == fill) begin
          result_next.last = 1'b1;
          state_next       = oli_pkg::S_IDLE;
        end else begin
          idx_next = idx_inc;
        end
      end
      default: begin
        state_next = oli_pkg::S_IDLE;
      end
    endcase
  end

  `OLI_ASSERT_NOW(a_fill_max, 1'b1, fill <= oli_pkg::DEPTH_C)
  `OLI_ASSERT_NOW(a_write_in_ins, ram_req.we, state == oli_pkg::S_INS)
  `OLI_ASSERT_NOW(a_last_idle, strobe && result.last, state == oli_pkg::S_IDLE)
  `OLI_ASSERT_NEXT(a_ins_start,
    accept && fill != oli_pkg::DEPTH_C &&
    (item.kind == oli_pkg::KIND_PREPEND || item.kind == oli_pkg::KIND_INSERT),
    state == oli_pkg::S_INS)

endmodule

/* design/ordered_list_insert.sv */
// insert or prepend: busy for the whole list sweep, one status beat at the end
// read: busy during the read-out sweep, one entry beat per cycle via registered read and result
// full insert, empty read: one beat the cycle after acceptance, not busy
// rate is set by a single memory sweeping the list one entry per cycle
// synchronous reset empties the list; results cannot be stalled
// ----------------------------------------------------------------------------
// ordered_list_insert
// ordered store of signed values with prepend, ordered insert and read out
// ----------------------------------------------------------------------------
module ordered_list_insert (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  oli_pkg::item_t    item,
  output logic              busy,
  output logic              strobe,
  output oli_pkg::result_t  result
);

  oli_pkg::ram_req_t        ram_req;
  logic [oli_pkg::VW-1:0]   rdata;

  oli_ram u_ram (
    .clk   (clk),
    .req   (ram_req),
    .rdata (rdata)
  );

  oli_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .item    (item),
    .busy    (busy),
    .strobe  (strobe),
    .result  (result),
    .ram_req (ram_req),
    .rdata   (rdata)
  );

endmodule

/* tb/ordered_list_insert_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// ordered_list_insert_tb
// drives prepend, ordered insert, read and unused-kind commands into the
// ordered list store with random idle gaps, keeps a shadow list to work
// out the status and entry beats each command should cause, and checks
// every result beat against the oldest outstanding one
// ----------------------------------------------------------------------------
module ordered_list_insert_tb;

  typedef struct {
    oli_pkg::item_t beat;
    int             gap;
    bit             drain;
  } cmd_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             start = 1'b0;
  oli_pkg::item_t   item = '0;
  logic             busy;
  logic             strobe;
  oli_pkg::result_t result;

  cmd_t             cmd_queue[$];
  oli_pkg::result_t due_results[$];

  logic signed [oli_pkg::VW-1:0] list_vals[oli_pkg::DEPTH];
  int      list_len = 0;
  bit      taken = 1'b0;
  int      gap_left = 0;
  int      n_errors = 0;

  // generator-side copy of stored values, used only to aim at ties
  logic signed [oli_pkg::VW-1:0] gen_vals[$];

  ordered_list_insert dut (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .item   (item),
    .busy   (busy),
    .strobe (strobe),
    .result (result)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic oli_pkg::result_t make_result(oli_pkg::status_t s,
                                                   logic signed [oli_pkg::VW-1:0] v, logic l);
    oli_pkg::result_t r;
    r.status      = s;
    r.entry_value = v;
    r.last        = l;
    return r;
  endfunction

  task automatic predict_list_op(oli_pkg::item_t b);
    logic signed [oli_pkg::VW-1:0] v;
    int pos;
    v = b.value;
    pos = 0;
    case (oli_pkg::kind_t'(b.kind))
      oli_pkg::KIND_PREPEND, oli_pkg::KIND_INSERT: begin
        if (list_len >= oli_pkg::DEPTH) begin
          due_results.push_back(make_result(oli_pkg::ST_FULL, '0, 1'b1));
        end else begin
          if (oli_pkg::kind_t'(b.kind) == oli_pkg::KIND_INSERT) begin
            while (pos < list_len && list_vals[pos] < v) pos++;
          end
          for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = v;
          list_len++;
          due_results.push_back(make_result(oli_pkg::ST_STORED, '0, 1'b1));
        end
      end
      oli_pkg::KIND_READ: begin
        if (list_len == 0) begin
          due_results.push_back(make_result(oli_pkg::ST_EMPTY, '0, 1'b1));
        end else begin
          for (int i = 0; i < list_len; i++)
            due_results.push_back(make_result(oli_pkg::ST_ENTRY, list_vals[i],
                                              i == list_len - 1));
        end
      end
      default: ;
    endcase
  endtask

  // acceptance and result check at the rising edge
  always @(posedge clk) begin
    oli_pkg::result_t want;
    if (!rst) begin
      if (start && !busy) begin
        predict_list_op(item);
        taken = 1'b1;
      end
      if (strobe) begin
        if (due_results.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("unexpected beat: status %0d value %0d last %0b",
                     result.status, result.entry_value, result.last);
        end else begin
          want = due_results.pop_front();
          if (result.status !== want.status || result.entry_value !== want.entry_value ||
              result.last !== want.last) begin
            n_errors++;
            if (n_errors <= 10)
              $display("mismatch: expected status %0d value %0d last %0b, got %0d %0d %0b",
                       want.status, want.entry_value, want.last,
                       result.status, result.entry_value, result.last);
          end
        end
      end
    end
  end

  // command driver, inputs change at the falling edge
  always @(negedge clk) begin
    logic           nxt_start;
    oli_pkg::item_t nxt_item;
    cmd_t           c;
    if (!rst) begin
      nxt_start = start;
      nxt_item  = item;
      if (start && taken) nxt_start = 1'b0;
      taken = 1'b0;
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (cmd_queue.size() > 0 &&
                     !(cmd_queue[0].drain && due_results.size() > 0)) begin
          c = cmd_queue.pop_front();
          nxt_start = 1'b1;
          nxt_item  = c.beat;
          gap_left  = c.gap;
        end
      end
      start <= nxt_start;
      item  <= nxt_item;
    end
  end

  function automatic int pick_gap(int idx);
    int r;
    if ((idx / 30) % 3 == 1) return 0;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  task automatic add_cmd(oli_pkg::kind_t k, logic signed [oli_pkg::VW-1:0] v, bit drain);
    cmd_t c;
    c.beat.kind  = k;
    c.beat.value = v;
    c.gap        = pick_gap(cmd_queue.size());
    c.drain      = drain;
    if ((k == oli_pkg::KIND_PREPEND || k == oli_pkg::KIND_INSERT) &&
        gen_vals.size() < oli_pkg::DEPTH)
      gen_vals.push_back(v);
    cmd_queue.push_back(c);
  endtask

  function automatic logic signed [oli_pkg::VW-1:0] pick_value();
    int r;
    r = $urandom_range(0, 7);
    if (r < 2 && gen_vals.size() > 0) return gen_vals[$urandom_range(0, gen_vals.size() - 1)];
    if (r == 2) begin
      case ($urandom_range(0, 3))
        0: return 32'sh8000_0000;
        1: return 32'sh7fff_ffff;
        2: return '0;
        default: return -1;
      endcase
    end
    return $urandom;
  endfunction

  initial begin
    int r;
    // directed: empty list, extremes, ties, overflowing differences
    add_cmd(oli_pkg::KIND_READ,    '0, 1'b0);
    add_cmd(oli_pkg::KIND_INSERT,  '0, 1'b0);
    add_cmd(oli_pkg::KIND_INSERT,  32'sh7fff_ffff, 1'b0);
    add_cmd(oli_pkg::KIND_INSERT,  32'sh8000_0000, 1'b0);
    add_cmd(oli_pkg::KIND_INSERT,  -1, 1'b0);
    add_cmd(oli_pkg::KIND_INSERT,  32'sh7fff_ffff, 1'b0);
    add_cmd(oli_pkg::KIND_INSERT,  32'sh8000_0000, 1'b0);
    add_cmd(oli_pkg::KIND_INSERT,  1, 1'b0);
    add_cmd(oli_pkg::KIND_INSERT,  32'sh7fff_fffe, 1'b0);
    add_cmd(oli_pkg::KIND_PREPEND, 5, 1'b0);
    add_cmd(oli_pkg::KIND_PREPEND, 32'sh8000_0000, 1'b0);
    add_cmd(oli_pkg::KIND_NONE,    32'shffff_ffff, 1'b0);
    add_cmd(oli_pkg::KIND_INSERT,  32'shaaaa_aaaa, 1'b0);
    add_cmd(oli_pkg::KIND_READ,    32'sh5555_5555, 1'b1);
    // random: fills the list, then drops and read-outs on a full store
    for (int n = 0; n < 216; n++) begin
      r = $urandom_range(0, 99);
      if (r < 40)      add_cmd(oli_pkg::KIND_INSERT,  pick_value(), n % 45 == 0);
      else if (r < 62) add_cmd(oli_pkg::KIND_PREPEND, pick_value(), n % 45 == 0);
      else if (r < 94) add_cmd(oli_pkg::KIND_READ,    $urandom, n % 45 == 0);
      else             add_cmd(oli_pkg::KIND_NONE,    $urandom, n % 45 == 0);
    end

    repeat (6) @(posedge clk);
    @(negedge clk) rst = 1'b0;

    while (cmd_queue.size() > 0 || start) @(posedge clk);
    while (due_results.size() > 0) @(posedge clk);
    repeat (oli_pkg::DEPTH + 8) @(posedge clk);
    n_errors += due_results.size();
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule
